/* hdl/sfc_pkg.sv */
package sfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [CountW-1:0] CountLimit = 9'd256;
  localparam logic [CountW-1:0] MinFrame   = 9'd7;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegHeaderFirst  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderSecond = 8'd1;
  localparam logic [CfgIdxW-1:0] RegTailFirst    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTailSecond   = 8'd3;

  // register reset values
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'd85;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'd0;
  localparam logic [ByteW-1:0] TailFirstRst    = 8'd0;
  localparam logic [ByteW-1:0] TailSecondRst   = 8'd170;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] tail_first;
    logic [ByteW-1:0] tail_second;
  } cfg_t;

endpackage

/* hdl/serial_frame_checker_top.sv */
// an accepted item goes through the input register into the frame state; the verdict of a
//   final byte is registered on out_valid_o/frame_ok_o once the result slot is free
// throughput: one item per cycle unless stalled; single input register and result register
// in_stall_o rises only while a final byte waits behind an unread verdict
// reset: rst_ni asynchronous active low clears pipeline valids, frame state and loads
//   the register reset values
module serial_frame_checker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sfc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                        end_of_frame_i,
  // result item channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        frame_ok_o,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfc_pkg::ByteW-1:0]    cfg_data_i
);
  import sfc_pkg::*;

  cfg_t cfg;

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // result register
  logic out_vld_q, out_vld_d;
  logic ok_q;

  logic slot_free;   // result register can take a verdict this edge
  logic advance;     // input register item moves into the frame state
  logic in_take;     // new item accepted
  logic ok;

  sfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // output slot is free when empty or when its verdict leaves this edge
  assign slot_free = !out_vld_q || !out_stall_i;
  // only a final byte needs the result slot
  assign advance   = in_vld_q && (!in_last_q || slot_free);
  // input register holds while its item cannot move on
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  sfc_frame_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .ok_o   (ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
      in_last_q <= end_of_frame_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (slot_free) begin
      out_vld_d = advance && in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && advance && in_last_q) begin
      ok_q <= ok;
    end
  end

  assign out_valid_o = out_vld_q;
  assign frame_ok_o  = ok_q;

endmodule

/* hdl/sfc_cfg_regs.sv */
module sfc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfc_pkg::ByteW-1:0]   cfg_data_i,
  output sfc_pkg::cfg_t              cfg_o
);
  import sfc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHeaderFirst:  cfg_d.header_first  = cfg_data_i;
        RegHeaderSecond: cfg_d.header_second = cfg_data_i;
        RegTailFirst:    cfg_d.tail_first    = cfg_data_i;
        RegTailSecond:   cfg_d.tail_second   = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstRst;
      cfg_q.header_second <= HeaderSecondRst;
      cfg_q.tail_first    <= TailFirstRst;
      cfg_q.tail_second   <= TailSecondRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/sfc_frame_state.sv */
module sfc_frame_state (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [sfc_pkg::ByteW-1:0] byte_i,
  input  logic                     last_i,
  input  sfc_pkg::cfg_t            cfg_i,
  output logic                     ok_o
);
  import sfc_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  // two newest bytes before this one; counting this byte, r1_q is the third history
  // entry, which is only ever read at the final byte
  logic [ByteW-1:0]  r0_q, r1_q;
  logic [ByteW-1:0]  payload_sum;

  // next frame state for this byte
  always_comb begin
    hdr_ok_d = hdr_ok_q;
    if (count_q == 9'd0 && byte_i != cfg_i.header_first)  hdr_ok_d = 1'b0;
    if (count_q == 9'd1 && byte_i != cfg_i.header_second) hdr_ok_d = 1'b0;
    len_d   = (count_q == 9'd2) ? byte_i : len_q;
    sum_d   = (count_q >= 9'd2) ? sum_q + byte_i : sum_q;
    count_d = (count_q < CountLimit) ? count_q + 9'd1 : count_q;
  end

  // checksum covers length byte up to the byte before the checksum
  assign payload_sum = sum_d - byte_i - r0_q - r1_q;

  assign ok_o = (count_d >= MinFrame)
             && hdr_ok_d
             && (r0_q == cfg_i.tail_first)
             && (byte_i == cfg_i.tail_second)
             && (count_d == {1'b0, len_d})
             && (r1_q == ~payload_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      hdr_ok_q <= 1'b1;
      len_q    <= '0;
      sum_q    <= '0;
      r0_q     <= '0;
      r1_q     <= '0;
    end else if (step_i) begin
      if (last_i) begin
        count_q  <= '0;
        hdr_ok_q <= 1'b1;
        len_q    <= '0;
        sum_q    <= '0;
        r0_q     <= '0;
        r1_q     <= '0;
      end else begin
        count_q  <= count_d;
        hdr_ok_q <= hdr_ok_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
        r0_q     <= byte_i;
        r1_q     <= r0_q;
      end
    end
  end

endmodule

/* hdl/sfc_checker.sv */
module sfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic frame_ok_o,
  input logic cfg_ready_o
);

  // a held result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // a held result keeps its verdict
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(frame_ok_o))
    else $error("verdict changed while stalled");

  // input stalls only while a verdict is blocked downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i || !in_valid_i |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind serial_frame_checker_top sfc_checker u_sfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .frame_ok_o  (frame_ok_o),
  .cfg_ready_o (cfg_ready_o)
);

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import sfc_pkg::*;

  typedef logic [ByteW-1:0] byte_t;

  // one input item: a frame byte and its final-byte mark
  typedef struct packed {
    byte_t data;
    logic  eof;
  } rx_item_t;

  // shapes of generated frames
  typedef enum int {
    FrmGood,
    FrmFlip,
    FrmBadLen,
    FrmShort,
    FrmNoise
  } frame_kind_e;

  // clock, reset and dut-facing signals, the driven ones known from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  byte_t               data_byte = '0;
  logic                end_of_frame = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                frame_ok;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  byte_t               cfg_data = '0;

  // register image as the dut should hold it
  cfg_t regs_model = '{header_first: HeaderFirstRst, header_second: HeaderSecondRst,
                       tail_first: TailFirstRst, tail_second: TailSecondRst};

  // running frame state of the predictor
  logic [CountW-1:0] frm_count = '0;
  logic              frm_hdr_ok = 1'b1;
  byte_t             frm_len = '0;
  byte_t             frm_sum = '0;
  byte_t             frm_hist [3] = '{default: '0};  // entry 0 newest

  // items waiting for the driver, verdicts waiting for the dut
  rx_item_t pending_bytes[$];
  logic     verdicts_due[$];
  byte_t    frame_buf[$];

  int       queued_total = 0;
  int       accepted_total = 0;
  int       error_count = 0;
  int       cyc = 0;
  rx_item_t next_item;
  logic     want;

  serial_frame_checker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_frame_i (end_of_frame),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_ok_o     (frame_ok),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("serial_frame_checker_top test failed");
    $finish;
  end

  task automatic flag_error(input string what);
    if (error_count < 30) $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // random idle with a chance of 14 in a hundred, except for a calm window
  function automatic logic take_break();
    if ((cyc % 1200) >= 400 && (cyc % 1200) < 700) return 1'b0;
    return ($urandom_range(99) < 14);
  endfunction

  // predictor: fold one accepted byte into the frame state, queue a verdict on the final byte
  function automatic void absorb_byte(input byte_t b, input logic eof);
    byte_t chk_want;
    logic  ok;
    if (frm_count == 0 && b != regs_model.header_first) frm_hdr_ok = 1'b0;
    if (frm_count == 1 && b != regs_model.header_second) frm_hdr_ok = 1'b0;
    if (frm_count == 2) frm_len = b;
    if (frm_count >= 2) frm_sum = frm_sum + b;
    frm_hist[2] = frm_hist[1];
    frm_hist[1] = frm_hist[0];
    frm_hist[0] = b;
    // count saturates so an oversized frame never matches its length byte
    if (frm_count < CountLimit) frm_count = frm_count + 1'b1;
    if (eof) begin
      // checksum byte is the complement of the sum from the length byte up to it
      chk_want = 8'hFF - byte_t'(frm_sum - frm_hist[0] - frm_hist[1] - frm_hist[2]);
      ok = (frm_count >= MinFrame) && frm_hdr_ok
        && (frm_hist[1] == regs_model.tail_first)
        && (frm_hist[0] == regs_model.tail_second)
        && (frm_count == {1'b0, frm_len})
        && (frm_hist[2] == chk_want);
      verdicts_due.insert(verdicts_due.size(), ok);
      frm_count = '0;
      frm_hdr_ok = 1'b1;
      frm_len = '0;
      frm_sum = '0;
      frm_hist = '{default: '0};
    end
  endfunction

  // driver: hold a stalled item, otherwise offer the next one unless idling
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        absorb_byte(data_byte, end_of_frame);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && !take_break()) begin
          next_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_item.data;
          end_of_frame <= next_item.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted verdict against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("verdict %0b with no frame pending", frame_ok));
        end else begin
          want = verdicts_due.pop_front();
          if (frame_ok !== want) flag_error($sformatf("frame_ok %b, want %b", frame_ok, want));
        end
      end
      out_stall <= take_break();
    end
  end

  // recompute the checksum byte in front of the two tail bytes
  function automatic void fix_checksum();
    byte_t s;
    s = '0;
    for (int i = 2; i < frame_buf.size() - 3; i++) s = s + frame_buf[i];
    frame_buf[frame_buf.size() - 3] = 8'hFF - s;
  endfunction

  // well-formed frame for the current registers, n payload bytes
  function automatic void build_good(input int n);
    frame_buf = {};
    frame_buf.insert(frame_buf.size(), regs_model.header_first);
    frame_buf.insert(frame_buf.size(), regs_model.header_second);
    frame_buf.insert(frame_buf.size(), byte_t'(n + 6));
    repeat (n) frame_buf.insert(frame_buf.size(), byte_t'($urandom));
    frame_buf.insert(frame_buf.size(), byte_t'(0));
    frame_buf.insert(frame_buf.size(), regs_model.tail_first);
    frame_buf.insert(frame_buf.size(), regs_model.tail_second);
    fix_checksum();
  endfunction

  // hand the built frame to the driver, mark on the final byte
  function automatic void flush_frame();
    foreach (frame_buf[i]) begin
      pending_bytes.insert(pending_bytes.size(),
                           rx_item_t'{frame_buf[i], i == frame_buf.size() - 1});
    end
    queued_total += frame_buf.size();
  endfunction

  // mostly well-formed frames with random content, the rest broken or noise
  function automatic void queue_random_frames(input int budget);
    int          target;
    int          r;
    int          n;
    int          pos;
    frame_kind_e kind;
    target = queued_total + budget;
    while (queued_total < target) begin
      r = $urandom_range(99);
      if (r < 62) kind = FrmGood;
      else if (r < 74) kind = FrmFlip;
      else if (r < 82) kind = FrmBadLen;
      else if (r < 90) kind = FrmShort;
      else kind = FrmNoise;
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      build_good(n);
      case (kind)
        FrmFlip: begin
          pos = $urandom_range(frame_buf.size() - 1);
          frame_buf[pos] = frame_buf[pos] ^ byte_t'($urandom_range(1, 255));
        end
        FrmBadLen: begin
          // wrong length byte, checksum kept consistent
          frame_buf[2] = frame_buf[2] + byte_t'($urandom_range(1, 255));
          fix_checksum();
        end
        FrmShort: begin
          build_good(0);
          pos = $urandom_range(1, 6);
          while (frame_buf.size() > pos) void'(frame_buf.pop_back());
        end
        FrmNoise: begin
          frame_buf = {};
          repeat ($urandom_range(1, 20)) frame_buf.insert(frame_buf.size(), byte_t'($urandom));
        end
        default: ;
      endcase
      flush_frame();
    end
  endfunction

  // wait until every item is taken and every verdict seen, then let the pipe empty
  task automatic wait_drain();
    int spins;
    spins = 0;
    while ((accepted_total != queued_total || verdicts_due.size() != 0) && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input byte_t val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegHeaderFirst:  regs_model.header_first = val;
      RegHeaderSecond: regs_model.header_second = val;
      RegTailFirst:    regs_model.tail_first = val;
      RegTailSecond:   regs_model.tail_second = val;
      default: ;  // unknown index, dut ignores it
    endcase
  endtask

  // all four registers plus one write to an unused index
  task automatic program_regs(input byte_t h1, input byte_t h2, input byte_t t1, input byte_t t2,
                              input logic [CfgIdxW-1:0] junk_idx, input byte_t junk_val);
    write_reg(RegHeaderFirst, h1);
    write_reg(RegTailSecond, t2);
    write_reg(junk_idx, junk_val);
    write_reg(RegHeaderSecond, h2);
    write_reg(RegTailFirst, t1);
  endtask

  // stimulus sequence, one register setting per phase
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest good frame, payload byte at its top value
    build_good(1);
    frame_buf[3] = 8'hFF;
    fix_checksum();
    flush_frame();
    // one-byte frame, length byte never seen
    frame_buf = {8'hFF};
    flush_frame();
    // six bytes, everything else consistent, too short
    build_good(0);
    flush_frame();
    // header mismatch on the first byte, payload byte zero
    build_good(1);
    frame_buf[3] = 8'h00;
    fix_checksum();
    frame_buf[0] = ~frame_buf[0];
    flush_frame();

    // reset register values
    queue_random_frames(35);
    wait_drain();

    // all registers at the bottom, then at the top
    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
    queue_random_frames(35);
    wait_drain();
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd4, 8'h00);
    queue_random_frames(35);
    wait_drain();

    for (int ph = 0; ph < 3; ph++) begin
      program_regs(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                   CfgIdxW'($urandom_range(4, 255)), byte_t'($urandom));
      if (ph == 0) begin
        // largest length byte, good frame of 255 bytes
        build_good(249);
        flush_frame();
      end else if (ph == 1) begin
        // oversized frame, count saturates past the length byte range
        build_good(249);
        void'(frame_buf.pop_back());
        void'(frame_buf.pop_back());
        repeat ($urandom_range(1, 45)) frame_buf.insert(frame_buf.size(), byte_t'($urandom));
        frame_buf.insert(frame_buf.size(), regs_model.tail_first);
        frame_buf.insert(frame_buf.size(), regs_model.tail_second);
        flush_frame();
      end
      queue_random_frames(35);
      wait_drain();
    end

    if (verdicts_due.size() != 0) flag_error($sformatf("%0d verdicts never came",
                                                       verdicts_due.size()));
    if (error_count == 0) begin
      $display("serial_frame_checker_top test passed");
    end else begin
      $display("serial_frame_checker_top test failed");
    end
    $finish;
  end

endmodule
